### sv/wav_stream_to_dac_samples_assert.svh
// ----------------------------------------------------------------------------
// wav stream assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef WAV_STREAM_TO_DAC_SAMPLES_ASSERT_SVH
`define WAV_STREAM_TO_DAC_SAMPLES_ASSERT_SVH

// same-cycle implication
`define WSD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wsd assertion failed");

// next-cycle implication
`define WSD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wsd assertion failed");

`endif

### sv/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// types, codes and constants of the wav stream decoder
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int MaxFrameBytes = 4;
	localparam int VolumeShift   = 4;
	localparam int MaxDecLog     = 7;   // factor 128

	// parser phases
	localparam logic [2:0] PH_RIFF  = 3'd0;
	localparam logic [2:0] PH_CHUNK = 3'd1;
	localparam logic [2:0] PH_FMT   = 3'd2;
	localparam logic [2:0] PH_SKIP  = 3'd3;
	localparam logic [2:0] PH_DATA  = 3'd4;
	localparam logic [2:0] PH_HALT  = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_FMT_OK = 2'd1;
	localparam logic [1:0] KIND_ERR    = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	// register indexes
	localparam logic CFG_VOLUME     = 1'b0;
	localparam logic CFG_RATE_LIMIT = 1'b1;

	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	localparam logic [4:0]  VOLUME_RESET = 5'd1;
	localparam logic [15:0] LIMIT_RESET  = 16'd16000;
	localparam logic [12:0] SAMPLE_MAX   = 13'h0FFF;

	// one classified request between front and back
	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] frame;   // raw frame bytes, byte 0 in the low bits
		logic [15:0] rate;
		logic        sixteen;
		logic        stereo;
		logic        last;
	} entry_t;

endpackage

### sv/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// byte parser: header, chunk walk, fmt check, frame gather and decimation
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 end_of_file,
	input  logic [15:0]          rate_limit,
	output logic [1:0]           push_cnt,
	output wsd_pkg::entry_t      push0,
	output wsd_pkg::entry_t      push1
);

	logic [2:0]  phase_q, phase_d;
	logic [31:0] pos_q, pos_d;
	logic [31:0] tag_q, tag_d;
	logic [31:0] len_q, len_d;
	logic        stereo_q, stereo_d;
	logic        sixteen_q, sixteen_d;
	logic [2:0]  fbytes_q, fbytes_d;
	logic [31:0] irate_q, irate_d;
	logic [7:0]  factor_q, factor_d;
	logic [7:0]  count_q, count_d;
	logic [23:0] buf_q, buf_d;
	logic        seen_q, seen_d;
	logic [15:0] code_q, code_d;
	logic [15:0] chan_q, chan_d;
	logic [15:0] align_q, align_d;
	logic [15:0] bits_q, bits_d;
	logic [1:0]  fill_q, fill_d;

	// fmt chunk fields after this byte
	logic [15:0] nf_code, nf_chan, nf_align, nf_bits;
	logic [31:0] nf_rate;
	logic [15:0] sh16;
	logic [31:0] sh32;
	logic        fmt_ok;
	logic [7:0]  le;
	logic [2:0]  hsel;
	logic [31:0] hrate;

	always_comb begin
		sh16 = {8'd0, data_byte} << {pos_q[0], 3'b000};
		sh32 = {24'd0, data_byte} << {pos_q[1:0], 3'b000};
		nf_code  = code_q;
		nf_chan  = chan_q;
		nf_align = align_q;
		nf_bits  = bits_q;
		nf_rate  = irate_q;
		if (pos_q < 32'd2)
			nf_code = code_q | sh16;
		else if (pos_q < 32'd4)
			nf_chan = chan_q | sh16;
		else if (pos_q < 32'd8)
			nf_rate = irate_q | sh32;
		else if (pos_q >= 32'd12 && pos_q < 32'd14)
			nf_align = align_q | sh16;
		else if (pos_q >= 32'd14 && pos_q < 32'd16)
			nf_bits = bits_q | sh16;
	end

	assign fmt_ok = (nf_code == 16'd1) && (nf_chan == 16'd1 || nf_chan == 16'd2)
		&& (nf_align != 16'd0) && (nf_align <= 16'(wsd_pkg::MaxFrameBytes))
		&& (nf_bits == 16'd8 || nf_bits == 16'd16);

	// rate halving as fixed shift compares
	always_comb begin
		for (int h = 0; h <= wsd_pkg::MaxDecLog; h++)
			le[h] = (nf_rate >> h) <= {16'd0, rate_limit};
		hsel = 3'd0;
		for (int h = wsd_pkg::MaxDecLog; h >= 0; h--)
			if (le[h]) hsel = 3'(h);
		hrate = nf_rate >> hsel;
	end

	logic        r1_v, r2_v, r3_v;
	logic [1:0]  r1_kind, r3_kind;
	logic [31:0] r1_frame;
	logic [15:0] r1_rate;
	logic [31:0] frame_w;
	wsd_pkg::entry_t e_r1, e_r2, e_r3;

	assign frame_w = {8'd0, buf_q} | ({24'd0, data_byte} << {fill_q, 3'b000});

	always_comb begin
		phase_d = phase_q; pos_d = pos_q; tag_d = tag_q; len_d = len_q;
		stereo_d = stereo_q; sixteen_d = sixteen_q; fbytes_d = fbytes_q;
		irate_d = irate_q; factor_d = factor_q; count_d = count_q; buf_d = buf_q;
		seen_d = seen_q; code_d = code_q; chan_d = chan_q; align_d = align_q;
		bits_d = bits_q; fill_d = fill_q;
		r1_v = 1'b0; r1_kind = wsd_pkg::KIND_ERR; r1_frame = 32'd0; r1_rate = 16'd0;
		r2_v = 1'b0; r3_v = 1'b0; r3_kind = wsd_pkg::KIND_ERR;

		unique case (phase_q)
			wsd_pkg::PH_RIFF: begin
				if (pos_q < 32'd4 || (pos_q >= 32'd8 && pos_q < 32'd12))
					tag_d = {tag_q[23:0], data_byte};
				if (pos_q == 32'd3 && tag_d != wsd_pkg::TAG_RIFF) begin
					r1_v = 1'b1; phase_d = wsd_pkg::PH_HALT;
				end else if (pos_q == 32'd11 && tag_d != wsd_pkg::TAG_WAVE) begin
					r1_v = 1'b1; phase_d = wsd_pkg::PH_HALT;
				end else if (pos_q >= 32'd11) begin
					phase_d = wsd_pkg::PH_CHUNK; pos_d = 32'd0;
				end else begin
					pos_d = pos_q + 32'd1;
				end
			end
			wsd_pkg::PH_CHUNK: begin
				if (pos_q < 32'd4) begin
					tag_d = {tag_q[23:0], data_byte};
					if (pos_q == 32'd0) len_d = 32'd0;
					pos_d = pos_q + 32'd1;
				end else begin
					len_d = len_q | sh32;
					if (pos_q >= 32'd7) begin
						pos_d = 32'd0;
						if (tag_q == wsd_pkg::TAG_FMT) begin
							code_d = 16'd0; chan_d = 16'd0; align_d = 16'd0; bits_d = 16'd0;
							irate_d = 32'd0;
							phase_d = wsd_pkg::PH_FMT;
							// empty fmt: code reads as zero
							if (len_d == 32'd0) begin
								r1_v = 1'b1; phase_d = wsd_pkg::PH_HALT;
							end
						end else if (tag_q == wsd_pkg::TAG_DATA) begin
							if (!seen_q) begin
								r1_v = 1'b1; phase_d = wsd_pkg::PH_HALT;
							end else begin
								phase_d = wsd_pkg::PH_DATA;
								fill_d = 2'd0; buf_d = 24'd0; count_d = 8'd1;
								if (len_d == 32'd0) begin
									r1_v = 1'b1; r1_kind = wsd_pkg::KIND_END;
									phase_d = wsd_pkg::PH_HALT;
								end
							end
						end else begin
							phase_d = (len_d == 32'd0) ? wsd_pkg::PH_CHUNK : wsd_pkg::PH_SKIP;
						end
					end else begin
						pos_d = pos_q + 32'd1;
					end
				end
			end
			wsd_pkg::PH_FMT: begin
				code_d = nf_code; chan_d = nf_chan; align_d = nf_align;
				bits_d = nf_bits; irate_d = nf_rate;
				pos_d = pos_q + 32'd1;
				if (pos_d == len_q) begin
					r1_v = 1'b1;
					if (!fmt_ok || !(|le)) begin
						phase_d = wsd_pkg::PH_HALT;
					end else begin
						stereo_d = (nf_chan == 16'd2);
						sixteen_d = (nf_bits == 16'd16);
						fbytes_d = nf_align[2:0];
						factor_d = 8'd1 << hsel;
						seen_d = 1'b1;
						r1_kind = wsd_pkg::KIND_FMT_OK;
						r1_rate = hrate[15:0];
						phase_d = wsd_pkg::PH_CHUNK;
						pos_d = 32'd0;
					end
				end
			end
			wsd_pkg::PH_SKIP: begin
				pos_d = pos_q + 32'd1;
				if (pos_d == len_q) begin
					phase_d = wsd_pkg::PH_CHUNK; pos_d = 32'd0;
				end
			end
			wsd_pkg::PH_DATA: begin
				if ({1'b0, fill_q} + 3'd1 >= fbytes_q) begin
					buf_d = 24'd0; fill_d = 2'd0;
					if (count_q >= factor_q) begin
						count_d = 8'd1;
						r1_v = 1'b1; r1_kind = wsd_pkg::KIND_SAMPLE; r1_frame = frame_w;
					end else begin
						count_d = count_q + 8'd1;
					end
				end else begin
					if (fill_q != 2'd3) buf_d = frame_w[23:0];
					fill_d = fill_q + 2'd1;
				end
				pos_d = pos_q + 32'd1;
				if (pos_d == len_q) begin
					r2_v = 1'b1; phase_d = wsd_pkg::PH_HALT;
				end
			end
			default: ;
		endcase

		if (end_of_file) begin
			if (phase_d == wsd_pkg::PH_DATA) begin
				r3_v = 1'b1; r3_kind = wsd_pkg::KIND_END;
			end else if (phase_d != wsd_pkg::PH_HALT) begin
				r3_v = 1'b1;
			end
			phase_d = wsd_pkg::PH_RIFF; pos_d = 32'd0; tag_d = 32'd0; len_d = 32'd0;
			stereo_d = 1'b0; sixteen_d = 1'b0; fbytes_d = 3'd1; irate_d = 32'd0;
			factor_d = 8'd1; count_d = 8'd1; buf_d = 24'd0; seen_d = 1'b0;
			code_d = 16'd0; chan_d = 16'd0; align_d = 16'd0; bits_d = 16'd0;
			fill_d = 2'd0;
		end
	end

	// order the results of this byte into at most two requests
	always_comb begin
		e_r1 = '{kind: r1_kind, frame: r1_frame, rate: r1_rate,
			sixteen: sixteen_q, stereo: stereo_q, last: 1'b0};
		e_r2 = '{kind: wsd_pkg::KIND_END, frame: 32'd0, rate: 16'd0,
			sixteen: 1'b0, stereo: 1'b0, last: 1'b0};
		e_r3 = '{kind: r3_kind, frame: 32'd0, rate: 16'd0,
			sixteen: 1'b0, stereo: 1'b0, last: 1'b0};
		push0 = r1_v ? e_r1 : (r2_v ? e_r2 : e_r3);
		push1 = (r1_v && r2_v) ? e_r2 : e_r3;
		push_cnt = 2'({1'b0, r1_v} + {1'b0, r2_v} + {1'b0, r3_v});
		if (!accept) push_cnt = 2'd0;
		push0.last = (push_cnt == 2'd1);
		push1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= wsd_pkg::PH_RIFF; pos_q <= 32'd0; tag_q <= 32'd0; len_q <= 32'd0;
			stereo_q <= 1'b0; sixteen_q <= 1'b0; fbytes_q <= 3'd1; irate_q <= 32'd0;
			factor_q <= 8'd1; count_q <= 8'd1; buf_q <= 24'd0; seen_q <= 1'b0;
			code_q <= 16'd0; chan_q <= 16'd0; align_q <= 16'd0; bits_q <= 16'd0;
			fill_q <= 2'd0;
		end else if (accept) begin
			phase_q <= phase_d; pos_q <= pos_d; tag_q <= tag_d; len_q <= len_d;
			stereo_q <= stereo_d; sixteen_q <= sixteen_d; fbytes_q <= fbytes_d;
			irate_q <= irate_d; factor_q <= factor_d; count_q <= count_d; buf_q <= buf_d;
			seen_q <= seen_d; code_q <= code_d; chan_q <= chan_d; align_q <= align_d;
			bits_q <= bits_d; fill_q <= fill_d;
		end
	end

endmodule

### sv/wsd_queue.sv
// ----------------------------------------------------------------------------
// wsd_queue
// four-entry request queue, up to two pushes and one pop per cycle
// ----------------------------------------------------------------------------
`include "wav_stream_to_dac_samples_assert.svh"

module wsd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [1:0]      push_cnt,
	input  wsd_pkg::entry_t push0,
	input  wsd_pkg::entry_t push1,
	input  logic            pop,
	output logic            room2,
	output logic            head_valid,
	output wsd_pkg::entry_t head
);

	wsd_pkg::entry_t slot_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       do_pop;

	assign head_valid = (cnt_q != 3'd0);
	assign head = slot_q[rd_q];
	assign room2 = (cnt_q <= 3'd2);
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) slot_q[wr_q] <= push0;
		if (push_cnt == 2'd2) slot_q[wr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 2'd0; rd_q <= 2'd0; cnt_q <= 3'd0;
		end else begin
			wr_q <= wr_q + push_cnt;
			rd_q <= rd_q + {1'b0, do_pop};
			cnt_q <= cnt_q + {1'b0, push_cnt} - {2'd0, do_pop};
		end
	end

	`WSD_ASSERT_IMP(a_no_overflow, push_cnt != 2'd0, cnt_q + {1'b0, push_cnt} <= 3'd4)
	`WSD_ASSERT_IMP(a_pop_nonempty, pop, head_valid)
	`WSD_ASSERT_NXT(a_single_drain, push_cnt == 2'd0 && do_pop, cnt_q == $past(cnt_q) - 3'd1)

endmodule

### sv/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// sample conversion, mix, volume scale and output register
// ----------------------------------------------------------------------------
module wsd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  wsd_pkg::entry_t head,
	input  logic [4:0]      volume,
	input  logic            out_stall,
	output logic            pop,
	output logic            out_valid,
	output logic [1:0]      kind,
	output logic [11:0]     sample,
	output logic [15:0]     output_rate,
	output logic            last_of_run
);

	logic [11:0] a, c;
	logic [12:0] mix;
	logic [16:0] prod;
	logic [12:0] scaled;
	logic [11:0] smp;
	logic        valid_q;

	always_comb begin
		if (head.sixteen) begin
			// signed 16-bit plus half scale, top 12 bits
			a = {~head.frame[15], head.frame[14:4]};
			c = {~head.frame[31], head.frame[30:20]};
		end else begin
			a = {head.frame[7:0], 4'h0};
			c = {head.frame[15:8], 4'h0};
		end
		mix = head.stereo ? (({1'b0, a} + {1'b0, c}) >> 1) : {1'b0, a};
		prod = mix[11:0] * volume;
		scaled = 13'(prod >> wsd_pkg::VolumeShift);
		smp = (scaled > wsd_pkg::SAMPLE_MAX) ? 12'hFFF : scaled[11:0];
	end

	assign pop = head_valid && (!valid_q || !out_stall);
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (!valid_q || !out_stall) valid_q <= head_valid;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind <= head.kind;
			sample <= (head.kind == wsd_pkg::KIND_SAMPLE) ? smp : 12'd0;
			output_rate <= head.rate;
			last_of_run <= head.last;
		end
	end

endmodule

### sv/wav_stream_to_dac_samples.sv
// ----------------------------------------------------------------------------
// wav_stream_to_dac_samples
// riff/wave pcm byte-stream decoder producing 12-bit dac samples
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// in        to block   in_valid/in_stall   data_byte, end_of_file
// out       from block out_valid/out_stall kind, sample, output_rate, last_of_run
// cfg       to block   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one byte per cycle is taken while the request queue has two free slots
// a byte's results pass through the request queue before they reach the output register
// the output register drains one request per cycle while out_stall is low, so a byte
//   with two results is presented to the back end as two requests in turn
// reset clears the parser, the queue and the output valid, and loads the registers
// out_stall holds the output register; in_stall rises once fewer than two
//   queue slots are free
// ----------------------------------------------------------------------------
module wav_stream_to_dac_samples (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [11:0] sample,
	output logic [15:0] output_rate,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	// configuration registers
	logic [4:0]  volume_q;
	logic [15:0] limit_q;

	// front to queue
	logic [1:0]      push_cnt;
	wsd_pkg::entry_t push0, push1;
	logic            accept;
	logic            room2;

	// queue to back
	logic            head_valid, pop;
	wsd_pkg::entry_t head;

	assign cfg_ready = 1'b1;
	assign in_stall = !room2;
	assign accept = in_valid && room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volume_q <= wsd_pkg::VOLUME_RESET;
			limit_q <= wsd_pkg::LIMIT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				wsd_pkg::CFG_VOLUME:     volume_q <= cfg_data[4:0];
				wsd_pkg::CFG_RATE_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: parse and classify each request
	wsd_front u_front (
		.clk(clk), .arst_n(arst_n), .accept(accept),
		.data_byte(data_byte), .end_of_file(end_of_file),
		.rate_limit(limit_q),
		.push_cnt(push_cnt), .push0(push0), .push1(push1)
	);

	// decoupling queue
	wsd_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push_cnt(push_cnt), .push0(push0), .push1(push1),
		.pop(pop), .room2(room2), .head_valid(head_valid), .head(head)
	);

	// back: convert and present results
	wsd_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .volume(volume_q),
		.out_stall(out_stall), .pop(pop), .out_valid(out_valid),
		.kind(kind), .sample(sample), .output_rate(output_rate),
		.last_of_run(last_of_run)
	);

endmodule

### tb/sv/wav_decode_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wav_decode_checker
// watches the byte, result and register channels of the wav decoder, keeps
// its own parser state, predicts the results of every accepted byte and
// compares them in order with what the block delivers
// ----------------------------------------------------------------------------
module wav_decode_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        end_of_file,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  kind,
	input  logic [11:0] sample,
	input  logic [15:0] output_rate,
	input  logic        last_of_run,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] sample;
		logic [15:0] rate;
		logic        last;
	} dac_result_t;

	dac_result_t results_due[$];

	logic [4:0]  vol;
	logic [15:0] limit;
	logic [2:0]  phase;
	logic [31:0] pos, tag, clen, in_rate, fbuf;
	logic        stereo, sixteen, fmt_seen;
	logic [2:0]  fbytes;
	logic [7:0]  dec_factor, dec_count, fill;
	logic [31:0] f_code, f_chan, f_align, f_bits;

	assign pending = results_due.size();

	function automatic void restart();
		phase = wsd_pkg::PH_RIFF; pos = 0; tag = 0; clen = 0;
		stereo = 0; sixteen = 0; fbytes = 1; in_rate = 0;
		dec_factor = 1; dec_count = 1; fbuf = 0; fmt_seen = 0;
		f_code = 0; f_chan = 0; f_align = 0; f_bits = 0; fill = 0;
	endfunction

	function automatic void push(logic [1:0] k, logic [11:0] s, logic [15:0] r);
		dac_result_t e;
		e.kind = k; e.sample = s; e.rate = r; e.last = 1'b0;
		results_due.push_back(e);
	endfunction

	function automatic void halt_error();
		push(wsd_pkg::KIND_ERR, 0, 0);
		phase = wsd_pkg::PH_HALT;
	endfunction

	function automatic void check_fmt();
		logic [31:0] r;
		int h;
		r = in_rate;
		h = 0;
		if (f_code != 1 || (f_chan != 1 && f_chan != 2) || f_align == 0 ||
				f_align > wsd_pkg::MaxFrameBytes || (f_bits != 8 && f_bits != 16)) begin
			halt_error();
			return;
		end
		while (r > {16'd0, limit} && h < 32) begin
			r = r >> 1;
			h++;
		end
		if (h > wsd_pkg::MaxDecLog) begin
			halt_error();
			return;
		end
		stereo = (f_chan == 2);
		sixteen = (f_bits == 16);
		fbytes = f_align[2:0];
		dec_factor = 8'(1 << h);
		fmt_seen = 1;
		push(wsd_pkg::KIND_FMT_OK, 0, r[15:0]);
		phase = wsd_pkg::PH_CHUNK;
		pos = 0;
	endfunction

	function automatic logic [11:0] to_dac(logic [7:0] b0, logic [7:0] b1,
			logic [7:0] b2, logic [7:0] b3);
		logic [15:0] a16, c16;
		logic [31:0] a, c, s;
		if (sixteen) begin
			a16 = {b1, b0} + 16'h8000;
			c16 = {b3, b2} + 16'h8000;
			a = a16 >> 4;
			c = c16 >> 4;
		end else begin
			a = {20'd0, b0, 4'd0};
			c = {20'd0, b1, 4'd0};
		end
		if (stereo)
			a = (a + c) >> 1;
		s = (a * vol) >> wsd_pkg::VolumeShift;
		return (s > 4095) ? 12'hFFF : s[11:0];
	endfunction

	function automatic void take_data(logic [7:0] b);
		logic [7:0] bb [4];
		for (int i = 0; i < 4; i++)
			bb[i] = 0;
		if (fill + 1 >= fbytes) begin
			for (int i = 0; i < fill && i < 3; i++)
				bb[i] = fbuf[8*i +: 8];
			if (fill < 4)
				bb[fill] = b;
			fbuf = 0;
			fill = 0;
			if (dec_count >= dec_factor) begin
				dec_count = 1;
				push(wsd_pkg::KIND_SAMPLE, to_dac(bb[0], bb[1], bb[2], bb[3]), 0);
			end else
				dec_count++;
		end else begin
			if (fill < 3)
				fbuf = fbuf | ({24'd0, b} << (8 * fill));
			fill++;
		end
		pos++;
		if (pos == clen) begin
			push(wsd_pkg::KIND_END, 0, 0);
			phase = wsd_pkg::PH_HALT;
		end
	endfunction

	function automatic void header_done();
		pos = 0;
		if (tag == wsd_pkg::TAG_FMT) begin
			f_code = 0; f_chan = 0; f_align = 0; f_bits = 0; in_rate = 0;
			phase = wsd_pkg::PH_FMT;
			if (clen == 0)
				check_fmt();
		end else if (tag == wsd_pkg::TAG_DATA) begin
			if (!fmt_seen) begin
				halt_error();
				return;
			end
			phase = wsd_pkg::PH_DATA;
			fill = 0; fbuf = 0; dec_count = 1;
			if (clen == 0) begin
				push(wsd_pkg::KIND_END, 0, 0);
				phase = wsd_pkg::PH_HALT;
			end
		end else
			phase = (clen == 0) ? wsd_pkg::PH_CHUNK : wsd_pkg::PH_SKIP;
	endfunction

	function automatic void predict_byte(logic [7:0] b, logic eof);
		int n0;
		logic [31:0] p, bw;
		dac_result_t e;
		n0 = results_due.size();
		p = pos;
		bw = {24'd0, b};
		case (phase)
			wsd_pkg::PH_RIFF: begin
				if (p < 4 || (p >= 8 && p < 12))
					tag = (tag << 8) | bw;
				if (p == 3 && tag != wsd_pkg::TAG_RIFF)
					halt_error();
				else if (p == 11 && tag != wsd_pkg::TAG_WAVE)
					halt_error();
				else if (p >= 11) begin
					phase = wsd_pkg::PH_CHUNK;
					pos = 0;
				end else
					pos++;
			end
			wsd_pkg::PH_CHUNK: begin
				if (p < 4) begin
					tag = (tag << 8) | bw;
					if (p == 0)
						clen = 0;
					pos++;
				end else begin
					clen = clen | (bw << (8 * ((p - 4) & 3)));
					if (p >= 7)
						header_done();
					else
						pos++;
				end
			end
			wsd_pkg::PH_FMT: begin
				if (p < 2)
					f_code = f_code | (bw << (8 * p));
				else if (p < 4)
					f_chan = f_chan | (bw << (8 * (p - 2)));
				else if (p < 8)
					in_rate = in_rate | (bw << (8 * (p - 4)));
				else if (p >= 12 && p < 14)
					f_align = f_align | (bw << (8 * (p - 12)));
				else if (p >= 14 && p < 16)
					f_bits = f_bits | (bw << (8 * (p - 14)));
				pos++;
				if (pos == clen)
					check_fmt();
			end
			wsd_pkg::PH_SKIP: begin
				pos++;
				if (pos == clen) begin
					phase = wsd_pkg::PH_CHUNK;
					pos = 0;
				end
			end
			wsd_pkg::PH_DATA: take_data(b);
			default: ;
		endcase
		if (eof) begin
			if (phase == wsd_pkg::PH_DATA)
				push(wsd_pkg::KIND_END, 0, 0);
			else if (phase != wsd_pkg::PH_HALT)
				push(wsd_pkg::KIND_ERR, 0, 0);
			restart();
		end
		if (results_due.size() > n0) begin
			e = results_due.pop_back();
			e.last = 1'b1;
			results_due.push_back(e);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		dac_result_t e;
		if (!arst_n) begin
			results_due.delete();
			vol = wsd_pkg::VOLUME_RESET;
			limit = wsd_pkg::LIMIT_RESET;
			restart();
			fail_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == wsd_pkg::CFG_VOLUME)
					vol = cfg_data[4:0];
				else
					limit = cfg_data;
			end
			if (in_valid && !in_stall)
				predict_byte(data_byte, end_of_file);
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					$error("result with nothing expected: kind %0d", kind);
					fail_count <= fail_count + 1;
				end else begin
					e = results_due.pop_front();
					if (kind !== e.kind || sample !== e.sample || output_rate !== e.rate ||
							last_of_run !== e.last)
						fail_count <= fail_count + 1;
					if (kind !== e.kind)
						$error("kind: expected %0d, got %0d", e.kind, kind);
					if (sample !== e.sample)
						$error("sample: expected %0d, got %0d", e.sample, sample);
					if (output_rate !== e.rate)
						$error("output_rate: expected %0d, got %0d", e.rate, output_rate);
					if (last_of_run !== e.last)
						$error("last_of_run: expected %0d, got %0d", e.last, last_of_run);
				end
			end
		end
	end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives wav files byte by byte into the decoder, writes the gain and rate
// limit between files, and stalls the result side at random; the checker
// predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [7:0]  data_byte = 0;
	logic        end_of_file = 0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [1:0]  kind;
	logic [11:0] sample;
	logic [15:0] output_rate;
	logic        last_of_run;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic        cfg_index = 0;
	logic [15:0] cfg_data = 0;
	int          fail_count;
	int          pending;
	int          byte_total = 0;
	int          cycle_count = 0;
	bit          hold_long = 0;

	// file image under construction
	logic [7:0]  file_bytes[$];

	always #5 clk = ~clk;

	wav_stream_to_dac_samples i_dut (.*);

	wav_decode_checker i_checker (.*);

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > 400000) begin
			$display("tb_top failed");
			$finish;
		end
	end

	// result side: random stall, with one long hold-off
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				hold_long = 0;
			end
			gap = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0)
				gap = 0;
			if (gap != 0) begin
				out_stall <= 1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 0;
			@(posedge clk);
		end
	end

	task automatic put32(logic [31:0] w);
		for (int i = 0; i < 4; i++)
			file_bytes.push_back(w[31 - 8*i -: 8]);
	endtask

	task automatic put_le(logic [31:0] w, int n);
		for (int i = 0; i < n; i++)
			file_bytes.push_back(w[8*i +: 8]);
	endtask

	// send the queued file; the last byte carries end_of_file
	task automatic send_file(bit busy);
		int gap;
		while (file_bytes.size() > 0) begin
			gap = busy ? 0 : $urandom_range(0, 5);
			if (gap != 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			in_valid <= 1;
			data_byte <= file_bytes[0];
			end_of_file <= (file_bytes.size() == 1);
			@(posedge clk);
			while (in_stall)
				@(posedge clk);
			void'(file_bytes.pop_front());
			byte_total++;
		end
		in_valid <= 0;
		end_of_file <= 0;
		@(posedge clk);
	endtask

	task automatic write_reg(logic idx, int val);
		while (pending != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= 16'(val);
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	// well-formed file with random content; flaws picks the breakage
	task automatic build_wav(int flaws, int chans, int bits, int align,
			logic [31:0] rate, int nbytes);
		put32((flaws == 1) ? 32'h52494647 : wsd_pkg::TAG_RIFF);
		put_le($urandom, 4);
		put32((flaws == 2) ? 32'h57415646 : wsd_pkg::TAG_WAVE);
		if ($urandom_range(0, 3) == 0) begin
			// unknown chunk to skip
			int sk;
			sk = $urandom_range(0, 6);
			put32(32'h4c495354);
			put_le(sk, 4);
			for (int i = 0; i < sk; i++)
				file_bytes.push_back(8'($urandom));
		end
		if (flaws != 3) begin
			int flen;
			flen = (flaws == 4) ? $urandom_range(0, 15) : 16 + $urandom_range(0, 1) * 2;
			put32(wsd_pkg::TAG_FMT);
			put_le(flen, 4);
			put_le(1, 2); put_le(chans, 2); put_le(rate, 4);
			put_le($urandom, 4); put_le(align, 2); put_le(bits, 2);
			for (int i = 0; i < 2; i++)
				file_bytes.push_back(8'($urandom));
			// trim to the stated length
			repeat (18 - flen)
				void'(file_bytes.pop_back());
		end
		put32(wsd_pkg::TAG_DATA);
		put_le((flaws == 5) ? nbytes + 3 : nbytes, 4);
		for (int i = 0; i < nbytes; i++)
			file_bytes.push_back(8'($urandom));
		if (flaws == 6)
			repeat ($urandom_range(1, 3))
				file_bytes.push_back(8'($urandom));
	endtask

	initial begin
		int ch, bt, al, fl;
		logic [31:0] rt;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of formats and the special cases
		build_wav(0, 1, 8, 1, 8000, 6); send_file(0);
		build_wav(0, 2, 16, 4, 44100, 12); send_file(0);
		build_wav(1, 1, 8, 1, 8000, 2); send_file(0);
		build_wav(2, 1, 8, 1, 8000, 2); send_file(0);
		build_wav(3, 1, 8, 1, 8000, 2); send_file(0);
		build_wav(4, 1, 8, 1, 8000, 2); send_file(0);
		build_wav(0, 1, 8, 1, 8000, 0); send_file(0);
		build_wav(0, 1, 16, 1, 32'hFFFFFFFF, 4); send_file(0);
		for (int i = 0; i < 8; i++)
			file_bytes.push_back({i[0] ? 8'hFF : 8'h00});
		send_file(0);

		write_reg(wsd_pkg::CFG_VOLUME, 16);
		write_reg(wsd_pkg::CFG_RATE_LIMIT, 65535);
		build_wav(0, 2, 8, 2, 96000, 8); send_file(0);
		write_reg(wsd_pkg::CFG_VOLUME, 31);
		write_reg(wsd_pkg::CFG_RATE_LIMIT, 1);
		build_wav(0, 1, 16, 2, 200, 8); send_file(0);
		write_reg(wsd_pkg::CFG_VOLUME, 0);
		build_wav(0, 1, 8, 1, 100, 4); send_file(0);

		// long hold-off on the result side while bytes keep coming
		write_reg(wsd_pkg::CFG_VOLUME, 16);
		write_reg(wsd_pkg::CFG_RATE_LIMIT, 16000);
		hold_long = 1;
		build_wav(0, 1, 8, 1, 16000, 200); send_file(1);

		while (byte_total < 1850) begin
			if ($urandom_range(0, 9) == 0) begin
				write_reg(wsd_pkg::CFG_VOLUME, $urandom_range(0, 31));
				write_reg(wsd_pkg::CFG_RATE_LIMIT,
					$urandom_range(0, 1) ? $urandom_range(1, 65535) : $urandom_range(1, 100));
			end
			ch = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : $urandom_range(1, 2);
			bt = $urandom_range(0, 9) == 0 ? $urandom_range(0, 24) :
				($urandom_range(0, 1) ? 16 : 8);
			al = $urandom_range(0, 9) == 0 ? $urandom_range(0, 6) : $urandom_range(1, 4);
			rt = $urandom_range(0, 1) ? $urandom_range(4000, 96000) : $urandom;
			fl = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
			build_wav(fl, ch, bt, al, rt, $urandom_range(0, 40));
			send_file($urandom_range(0, 7) == 0);
		end

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule

### filelist.f
+incdir+sv
sv/wsd_pkg.sv
sv/wsd_front.sv
sv/wsd_queue.sv
sv/wsd_back.sv
sv/wav_stream_to_dac_samples.sv
tb/sv/wav_decode_checker.sv
tb/sv/tb_top.sv
